### design/tile_residency_lru_tracker_assert.svh
// assertion macros shared by the tile residency tracker rtl
// expects clk and arst_n in the scope of each use
`ifndef TILE_RESIDENCY_LRU_TRACKER_ASSERT_SVH
`define TILE_RESIDENCY_LRU_TRACKER_ASSERT_SVH

// same-cycle implication, off while reset is applied
`define TRLT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, off while reset is applied
`define TRLT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### design/trlt_pkg.sv
// shared constants, codes and types of the tile residency tracker
// no dependencies
`timescale 1ns / 1ps

package trlt_pkg;

	localparam int GRID_ROWS      = 45;
	localparam int GRID_COLS      = 90;
	localparam int RESIDENT_LIMIT = 96;
	localparam int TILE_SLOTS     = GRID_ROWS * GRID_COLS;

	// fixed field widths
	localparam int FUNC_W   = 3;
	localparam int KEY_W    = 12;
	localparam int STATUS_W = 2;
	localparam int RCNT_W   = 7;
	localparam int STAMP_W  = 32;

	// tiles that a key can reach
	localparam int SLOT_CNT = (TILE_SLOTS > (1 << KEY_W)) ? (1 << KEY_W) : TILE_SLOTS;
	localparam int IDX_W    = $clog2(SLOT_CNT + 1);
	localparam int CNT_W    = $clog2(RESIDENT_LIMIT + 2);
	localparam int ENTRY_W  = STATUS_W + STAMP_W;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_USE        = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ARRIVE_OK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ARRIVE_BAD = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd3;

	// tile residency codes
	localparam logic [STATUS_W-1:0] TS_UNKNOWN = 2'd0;
	localparam logic [STATUS_W-1:0] TS_LOADING = 2'd1;
	localparam logic [STATUS_W-1:0] TS_READY   = 2'd2;
	localparam logic [STATUS_W-1:0] TS_ABSENT  = 2'd3;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_CLEAR,
		ST_SCAN,
		ST_EVICT,
		ST_DONE
	} trlt_state_t;

	// controller to datapath
	typedef struct packed {
		logic take_item;
		logic apply;
		logic clear_begin;
		logic scan_begin;
		logic sweep_wr;
		logic scan_rd;
		logic evict;
		logic out_load;
	} trlt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic need_evict;
		logic sweep_last;
		logic scan_done;
		logic out_busy;
	} trlt_sts_t;

endpackage

### design/trlt_if.sv
// valid/ready channel interfaces of the tile residency tracker
// depends on trlt_pkg
`timescale 1ns / 1ps

interface trlt_in_if;
	logic                          valid;
	logic                          ready;
	logic [trlt_pkg::FUNC_W-1:0]   func;
	logic [trlt_pkg::KEY_W-1:0]    tile_key;

	modport source (output valid, func, tile_key, input ready);
	modport sink (input valid, func, tile_key, output ready);
endinterface

interface trlt_out_if;
	logic                          valid;
	logic                          ready;
	logic [trlt_pkg::STATUS_W-1:0] tile_status;
	logic                          fetch_needed;
	logic                          evicted_valid;
	logic [trlt_pkg::KEY_W-1:0]    evicted_key;
	logic [trlt_pkg::RCNT_W-1:0]   resident_count;

	modport source (output valid, tile_status, fetch_needed, evicted_valid, evicted_key,
		resident_count, input ready);
	modport sink (input valid, tile_status, fetch_needed, evicted_valid, evicted_key,
		resident_count, output ready);
endinterface

### design/tile_residency_lru_tracker.sv
// tile residency tracker with least-recently-used eviction
// in_ch carries one operation and tile key per transfer, out_ch one result per item
// a plain item is decoded and applied, then its result goes to the output register; an arrival
//   that pushes the ready count over the limit scans the whole tile table, one
//   entry a cycle through the ram read port, and then releases the victim
// clear all rewrites every table entry, one a cycle
// a new item is taken only after the last one has loaded its result into the
//   output register, so an evicting arrival holds the input for its whole scan
// reset: the table is zeroed by a sweep over all SLOT_CNT entries (4050 at the
//   default grid), during which in_ch.ready stays low
// a finished result sits in the output register; a new item is taken while it
//   waits, but its own result is held back until the receiver has taken the old one
// depends on trlt_pkg, trlt_if, trlt_ctrl and trlt_dp
`timescale 1ns / 1ps

module tile_residency_lru_tracker (
	input  logic       clk,
	input  logic       arst_n,
	trlt_in_if.sink    in_ch,
	trlt_out_if.source out_ch
);

	// command and status between controller and datapath
	trlt_pkg::trlt_cmd_t cmd;
	trlt_pkg::trlt_sts_t sts;

	// sequencing: reset sweep, idle, decode, clear sweep, eviction scan, result hand-off
	trlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tile table ram, use clock, ready count, scan and output register
	trlt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_func      (in_ch.func),
		.in_key       (in_ch.tile_key),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.out_status   (out_ch.tile_status),
		.out_fetch    (out_ch.fetch_needed),
		.out_ev_valid (out_ch.evicted_valid),
		.out_ev_key   (out_ch.evicted_key),
		.out_count    (out_ch.resident_count)
	);

endmodule

### design/trlt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module trlt_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### design/trlt_dp.sv
// datapath of the tile residency tracker: tile table, use clock, scan and result registers
// depends on trlt_pkg, trlt_ram and the assertion header
`timescale 1ns / 1ps
`include "tile_residency_lru_tracker_assert.svh"

module trlt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  trlt_pkg::trlt_cmd_t           cmd,
	output trlt_pkg::trlt_sts_t           sts,
	input  logic [trlt_pkg::FUNC_W-1:0]   in_func,
	input  logic [trlt_pkg::KEY_W-1:0]    in_key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [trlt_pkg::STATUS_W-1:0] out_status,
	output logic                          out_fetch,
	output logic                          out_ev_valid,
	output logic [trlt_pkg::KEY_W-1:0]    out_ev_key,
	output logic [trlt_pkg::RCNT_W-1:0]   out_count
);

	// item registers
	logic [trlt_pkg::FUNC_W-1:0]   func_q;
	logic [trlt_pkg::KEY_W-1:0]    key_q;
	// block state
	logic [trlt_pkg::STAMP_W-1:0]  clk_q;
	logic [trlt_pkg::CNT_W-1:0]    cnt_q;
	logic [trlt_pkg::IDX_W-1:0]    idx_q;
	// scan
	logic                          scan_vld_s1;
	logic [trlt_pkg::KEY_W-1:0]    scan_key_s1;
	logic                          found_q;
	logic [trlt_pkg::KEY_W-1:0]    best_key_q;
	logic [trlt_pkg::STAMP_W-1:0]  best_stamp_q;
	// result and output registers
	logic [trlt_pkg::STATUS_W-1:0] res_status_q;
	logic                          res_fetch_q;
	logic                          res_ev_q;
	logic [trlt_pkg::KEY_W-1:0]    res_evkey_q;
	logic                          out_valid_q;
	logic [trlt_pkg::STATUS_W-1:0] out_status_q;
	logic                          out_fetch_q;
	logic                          out_ev_q;
	logic [trlt_pkg::KEY_W-1:0]    out_evkey_q;
	logic [trlt_pkg::RCNT_W-1:0]   out_count_q;

	// ram
	logic                          wr_en;
	logic [trlt_pkg::KEY_W-1:0]    wr_addr;
	logic [trlt_pkg::ENTRY_W-1:0]  wr_data;
	logic [trlt_pkg::KEY_W-1:0]    rd_addr;
	logic [trlt_pkg::ENTRY_W-1:0]  rd_data;
	logic [trlt_pkg::STATUS_W-1:0] rd_state;
	logic [trlt_pkg::STAMP_W-1:0]  rd_stamp;

	// apply step
	logic                          in_grid;
	logic [trlt_pkg::STAMP_W-1:0]  clk_inc;
	logic                          ap_wr;
	logic [trlt_pkg::ENTRY_W-1:0]  ap_data;
	logic [trlt_pkg::STAMP_W-1:0]  ap_clk;
	logic [trlt_pkg::CNT_W-1:0]    ap_cnt;
	logic [trlt_pkg::STATUS_W-1:0] ap_status;
	logic                          ap_fetch;
	logic                          issue_ok;
	logic                          scan_take;

	trlt_ram #(
		.WIDTH  (trlt_pkg::ENTRY_W),
		.DEPTH  (trlt_pkg::SLOT_CNT),
		.ADDR_W (trlt_pkg::KEY_W)
	) u_tiles (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_state = rd_data[trlt_pkg::ENTRY_W-1 -: trlt_pkg::STATUS_W];
	assign rd_stamp = rd_data[trlt_pkg::STAMP_W-1:0];
	assign rd_addr  = cmd.take_item ? in_key : trlt_pkg::KEY_W'(idx_q);

	assign in_grid  = (trlt_pkg::KEY_W + 1)'(key_q) < (trlt_pkg::KEY_W + 1)'(trlt_pkg::SLOT_CNT);
	assign clk_inc  = clk_q + trlt_pkg::STAMP_W'(1);
	assign issue_ok = idx_q != trlt_pkg::IDX_W'(trlt_pkg::SLOT_CNT);

	// state change of the addressed tile, from its stored entry
	always_comb begin
		ap_wr     = 1'b0;
		ap_data   = rd_data;
		ap_clk    = clk_q;
		ap_cnt    = cnt_q;
		ap_status = trlt_pkg::TS_UNKNOWN;
		ap_fetch  = 1'b0;
		if (in_grid) begin
			ap_status = rd_state;
			unique case (func_q)
				trlt_pkg::FN_USE: begin
					if (rd_state == trlt_pkg::TS_UNKNOWN) begin
						ap_wr     = 1'b1;
						ap_data   = {trlt_pkg::TS_LOADING, rd_stamp};
						ap_status = trlt_pkg::TS_LOADING;
						ap_fetch  = 1'b1;
					end else if (rd_state == trlt_pkg::TS_READY) begin
						ap_wr   = 1'b1;
						ap_clk  = clk_inc;
						ap_data = {trlt_pkg::TS_READY, clk_inc};
					end
				end
				trlt_pkg::FN_ARRIVE_OK: begin
					ap_wr     = 1'b1;
					ap_clk    = clk_inc;
					ap_data   = {trlt_pkg::TS_READY, clk_inc};
					ap_status = trlt_pkg::TS_READY;
					if (rd_state != trlt_pkg::TS_READY) begin
						ap_cnt = cnt_q + trlt_pkg::CNT_W'(1);
					end
				end
				trlt_pkg::FN_ARRIVE_BAD: begin
					ap_wr     = 1'b1;
					ap_clk    = clk_inc;
					ap_data   = {trlt_pkg::TS_ABSENT, clk_inc};
					ap_status = trlt_pkg::TS_ABSENT;
					if (rd_state == trlt_pkg::TS_READY && cnt_q != '0) begin
						ap_cnt = cnt_q - trlt_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// one write port: item update, victim release, or zero sweep
	always_comb begin
		wr_en   = (cmd.apply & ap_wr) | cmd.sweep_wr | cmd.evict;
		wr_data = '0;
		wr_addr = trlt_pkg::KEY_W'(idx_q);
		priority if (cmd.apply) begin
			wr_addr = key_q;
			wr_data = ap_data;
		end else if (cmd.evict) begin
			wr_addr = best_key_q;
		end
	end

	// oldest ready stamp, first key wins a tie
	assign scan_take = scan_vld_s1 && rd_state == trlt_pkg::TS_READY &&
		(!found_q || rd_stamp < best_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_begin || cmd.scan_begin) begin
				idx_q <= '0;
			end else if (cmd.sweep_wr || (cmd.scan_rd && issue_ok)) begin
				idx_q <= idx_q + trlt_pkg::IDX_W'(1);
			end
			scan_vld_s1 <= cmd.scan_rd && issue_ok;

			if (cmd.apply) begin
				clk_q <= ap_clk;
				cnt_q <= ap_cnt;
			end else if (cmd.clear_begin) begin
				cnt_q <= '0;
			end else if (cmd.evict) begin
				cnt_q <= cnt_q - trlt_pkg::CNT_W'(1);
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			func_q <= in_func;
			key_q  <= in_key;
		end
		scan_key_s1 <= trlt_pkg::KEY_W'(idx_q);

		if (cmd.scan_begin) begin
			found_q <= 1'b0;
		end else if (scan_take) begin
			found_q      <= 1'b1;
			best_key_q   <= scan_key_s1;
			best_stamp_q <= rd_stamp;
		end

		if (cmd.apply) begin
			res_status_q <= ap_status;
			res_fetch_q  <= ap_fetch;
			res_ev_q     <= 1'b0;
			res_evkey_q  <= '0;
		end else if (cmd.clear_begin) begin
			res_status_q <= trlt_pkg::TS_UNKNOWN;
			res_fetch_q  <= 1'b0;
			res_ev_q     <= 1'b0;
			res_evkey_q  <= '0;
		end else if (cmd.evict) begin
			res_ev_q    <= 1'b1;
			res_evkey_q <= best_key_q;
			if (best_key_q == key_q) begin
				res_status_q <= trlt_pkg::TS_UNKNOWN;
			end
		end

		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_fetch_q  <= res_fetch_q;
			out_ev_q     <= res_ev_q;
			out_evkey_q  <= res_evkey_q;
			out_count_q  <= trlt_pkg::RCNT_W'(cnt_q);
		end
	end

	assign sts.is_clear   = func_q == trlt_pkg::FN_CLEAR;
	assign sts.need_evict = func_q == trlt_pkg::FN_ARRIVE_OK && in_grid &&
		ap_cnt > trlt_pkg::CNT_W'(trlt_pkg::RESIDENT_LIMIT);
	assign sts.sweep_last = idx_q == trlt_pkg::IDX_W'(trlt_pkg::SLOT_CNT - 1);
	assign sts.scan_done  = scan_vld_s1 && scan_key_s1 == trlt_pkg::KEY_W'(trlt_pkg::SLOT_CNT - 1);
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_fetch    = out_fetch_q;
	assign out_ev_valid = out_ev_q;
	assign out_ev_key   = out_evkey_q;
	assign out_count    = out_count_q;

	`TRLT_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_q && !out_ready))
	`TRLT_ASSERT_IMP(a_count_in_limit, cmd.apply, cnt_q <= trlt_pkg::CNT_W'(trlt_pkg::RESIDENT_LIMIT))
	`TRLT_ASSERT_NXT(a_clock_step, 1'b1,
		clk_q == $past(clk_q) || clk_q == trlt_pkg::STAMP_W'($past(clk_q) + 1))
	`TRLT_ASSERT_IMP(a_victim_found, cmd.evict, found_q)

endmodule

### design/trlt_ctrl.sv
// controller state machine of the tile residency tracker
// depends on trlt_pkg
`timescale 1ns / 1ps

module trlt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  trlt_pkg::trlt_sts_t sts,
	output trlt_pkg::trlt_cmd_t cmd
);

	trlt_pkg::trlt_state_t state_q;
	trlt_pkg::trlt_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trlt_pkg::ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			trlt_pkg::ST_INIT: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = trlt_pkg::ST_IDLE;
				end
			end
			trlt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_item = 1'b1;
					state_nxt     = trlt_pkg::ST_DECODE;
				end
			end
			trlt_pkg::ST_DECODE: begin
				if (sts.is_clear) begin
					cmd.clear_begin = 1'b1;
					state_nxt       = trlt_pkg::ST_CLEAR;
				end else begin
					cmd.apply = 1'b1;
					if (sts.need_evict) begin
						cmd.scan_begin = 1'b1;
						state_nxt      = trlt_pkg::ST_SCAN;
					end else begin
						state_nxt = trlt_pkg::ST_DONE;
					end
				end
			end
			trlt_pkg::ST_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_nxt = trlt_pkg::ST_DONE;
				end
			end
			trlt_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_done) begin
					state_nxt = trlt_pkg::ST_EVICT;
				end
			end
			trlt_pkg::ST_EVICT: begin
				cmd.evict = 1'b1;
				state_nxt = trlt_pkg::ST_DONE;
			end
			trlt_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = trlt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = trlt_pkg::ST_INIT;
			end
		endcase
	end

endmodule
